FILE: hdl/flog2_pkg.sv
`default_nettype none
package flog2_pkg;

    localparam int FRAC_BITS = 24;
    localparam int WORD_W    = 32;
    localparam int ACC_W     = FRAC_BITS + 6;
    localparam int N_W       = 9;
    localparam int SUM_W     = FRAC_BITS + 10;
    localparam int POS_W     = $clog2(SUM_W);
    localparam int SIG_W     = 24;
    localparam int EXP_W     = 8;
    localparam int MANT_W    = 23;
    localparam int N_COEF    = 6;
    localparam int N_STEP    = N_COEF - 1;
    localparam int Q32_SH    = 32 - FRAC_BITS;
    localparam int EXP_OFF   = 127 - FRAC_BITS;
    localparam int EXP_BIAS  = 126;

    localparam logic [WORD_W-1:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [WORD_W-1:0] PINF_BITS = 32'h7F80_0000;
    localparam logic [WORD_W-1:0] NINF_BITS = 32'hFF80_0000;
    localparam logic [WORD_W-1:0] ZERO_BITS = 32'h0000_0000;
    localparam logic [EXP_W-1:0]  EXP_MAX   = 8'hFF;
    localparam logic [EXP_W-1:0]  EXP_MIN   = 8'h00;

    // c0..c5, each the nearest integer to ck * 2^32
    localparam logic signed [63:0] COEF_Q32 [N_COEF] = '{
        -64'sd16367317206, 64'sd44077187775, -64'sd62017480918,
        64'sd57551518089, -64'sd29713000366, 64'sd6478717648
    };

    // sideband that travels beside the datapath
    typedef struct packed {
        logic                    valid;
        logic                    spec;
        logic [WORD_W-1:0]       spec_bits;
        logic signed [N_W-1:0]   n;
    } t_side;

    // round a Q32 coefficient to FRAC_BITS fraction bits, half away from zero
    function automatic logic signed [ACC_W-1:0] coef_at(input int unsigned k);
        logic signed [63:0] c;
        logic [63:0]        mag;
        logic [63:0]        r;
        logic signed [63:0] s;
        c   = COEF_Q32[k];
        mag = (c < 0) ? 64'(-c) : 64'(c);
        r   = (mag + (64'd1 << (Q32_SH - 1))) >> Q32_SH;
        s   = (c < 0) ? -$signed(r) : $signed(r);
        return s[ACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/flog2_in_if.sv
`default_nettype none
interface flog2_in_if import flog2_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] x_bits;

    modport source (output valid, output x_bits, input ready);
    modport sink   (input valid, input x_bits, output ready);
endinterface
`default_nettype wire

FILE: hdl/flog2_out_if.sv
`default_nettype none
interface flog2_out_if import flog2_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] result_bits;

    modport source (output valid, output result_bits, input ready);
    modport sink   (input valid, input result_bits, output ready);
endinterface
`default_nettype wire

FILE: hdl/float_log2_polynomial_approx_core.sv
// Throughput: one request per cycle; the whole pipeline advances together and
// holds in place while a finished result waits at the output register.
// Reset: synchronous, active low; clears every stage valid bit, data is not reset.
`default_nettype none
module float_log2_polynomial_approx_core import flog2_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    flog2_in_if.sink   i_x,
    flog2_out_if.source o_result
);

    // Pipeline map:
    //   decode  : split the operand, pick special answers, form f and n
    //   horner  : five stages, one multiply-add each (c4 down to c0)
    //   to_float: sum, magnitude, leading-one search, normalize, round/pack
    // A single enable drives every stage, so a stall at the output freezes
    // the whole pipe and no request is lost or repeated.

    logic                     w_en;
    logic                     w_out_valid;
    logic [WORD_W-1:0]        w_out_bits;

    logic                     w_sgn;
    logic [EXP_W-1:0]         w_ex;
    logic [MANT_W-1:0]        w_man;
    logic [WORD_W-1:0]        w_sigx;
    t_side                    n_side;
    logic [FRAC_BITS-1:0]     n_f;

    logic                     r_valid;
    t_side                    r_side;
    logic [FRAC_BITS-1:0]     r_f;

    t_side                    w_side [N_STEP+1];
    logic signed [ACC_W-1:0]  w_acc  [N_STEP+1];
    logic [FRAC_BITS-1:0]     w_f    [N_STEP+1];

    // advance whenever the output slot is empty or is being drained
    assign w_en        = !w_out_valid || o_result.ready;
    assign i_x.ready   = w_en;

    // Decode. Order of the special cases matters: NaN first, then zero or
    // denormal (flushed, either sign gives -inf), then any other negative
    // value, then +inf.
    always_comb begin
        w_sgn  = i_x.x_bits[WORD_W-1];
        w_ex   = i_x.x_bits[WORD_W-2 -: EXP_W];
        w_man  = i_x.x_bits[MANT_W-1:0];
        // significand 1.m in the top bits, then keep FRAC_BITS of it
        w_sigx = {1'b1, w_man, 8'h00};
        n_f    = w_sigx[WORD_W-1 -: FRAC_BITS];

        n_side.valid     = i_x.valid;
        n_side.n         = $signed({1'b0, w_ex}) - N_W'(EXP_BIAS);
        n_side.spec      = 1'b1;
        n_side.spec_bits = ZERO_BITS;
        if (w_ex == EXP_MAX && w_man != '0) begin
            n_side.spec_bits = QNAN_BITS;
        end else if (w_ex == EXP_MIN) begin
            n_side.spec_bits = NINF_BITS;
        end else if (w_sgn) begin
            n_side.spec_bits = QNAN_BITS;
        end else if (w_ex == EXP_MAX) begin
            n_side.spec_bits = PINF_BITS;
        end else begin
            n_side.spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_x.valid;
        end
    end

    // hold the decoded operand for the first Horner stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side <= n_side;
            r_f    <= n_f;
        end
    end

    always_comb begin
        w_side[0]       = r_side;
        w_side[0].valid = r_valid;
    end

    // Horner seed is c5; each stage folds in the next lower coefficient
    assign w_acc[0] = coef_at(N_COEF - 1);
    assign w_f[0]   = r_f;

    for (genvar g = 0; g < N_STEP; g++) begin : g_horner
        flog2_horner_stage u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_side (w_side[g]),
            .i_acc  (w_acc[g]),
            .i_f    (w_f[g]),
            .i_coef (coef_at(N_STEP - 1 - g)),
            .o_side (w_side[g+1]),
            .o_acc  (w_acc[g+1]),
            .o_f    (w_f[g+1])
        );
    end

    // convert n * 2^FRAC_BITS + p to single precision; the last stage of
    // this unit is the output register
    flog2_to_float u_to_float (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_side (w_side[N_STEP]),
        .i_acc  (w_acc[N_STEP]),
        .o_valid(w_out_valid),
        .o_bits (w_out_bits)
    );

    assign o_result.valid       = w_out_valid;
    assign o_result.result_bits = w_out_bits;

endmodule
`default_nettype wire

FILE: hdl/flog2_horner_stage.sv
`default_nettype none
module flog2_horner_stage import flog2_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_side                   i_side,
    input  wire logic signed [ACC_W-1:0] i_acc,
    input  wire logic [FRAC_BITS-1:0]    i_f,
    input  wire logic signed [ACC_W-1:0] i_coef,
    output t_side                        o_side,
    output logic signed [ACC_W-1:0]      o_acc,
    output logic [FRAC_BITS-1:0]         o_f
);

    localparam int PROD_W = ACC_W + FRAC_BITS + 1;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_floor;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_valid;
    t_side                    r_side;
    logic signed [ACC_W-1:0]  r_acc;
    logic [FRAC_BITS-1:0]     r_f;

    // arithmetic shift of the product is floor(acc * f / 2^FRAC_BITS)
    always_comb begin
        w_prod  = PROD_W'(i_acc) * PROD_W'($signed({1'b0, i_f}));
        w_floor = w_prod >>> FRAC_BITS;
        n_acc   = w_floor[ACC_W-1:0] + i_coef;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_acc  <= n_acc;
            r_f    <= i_f;
        end
    end

    always_comb begin
        o_side       = r_side;
        o_side.valid = r_valid;
    end

    assign o_acc = r_acc;
    assign o_f   = r_f;

endmodule
`default_nettype wire

FILE: hdl/flog2_to_float.sv
`default_nettype none
module flog2_to_float import flog2_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire t_side                   i_side,
    input  wire logic signed [ACC_W-1:0] i_acc,
    output logic                         o_valid,
    output logic [WORD_W-1:0]            o_bits
);

    // stage A: n * 2^FRAC_BITS + acc
    logic                    r_a_valid;
    t_side                   r_a_side;
    logic signed [SUM_W-1:0] r_a_sum;
    // stage B: sign and magnitude
    logic                    r_b_valid;
    t_side                   r_b_side;
    logic                    r_b_neg;
    logic [SUM_W-1:0]        r_b_mag;
    // stage C: leading one position
    logic                    r_c_valid;
    t_side                   r_c_side;
    logic                    r_c_neg;
    logic                    r_c_zero;
    logic [SUM_W-1:0]        r_c_mag;
    logic [POS_W-1:0]        r_c_pos;
    // stage D: normalized word
    logic                    r_d_valid;
    t_side                   r_d_side;
    logic                    r_d_neg;
    logic                    r_d_zero;
    logic [POS_W-1:0]        r_d_pos;
    logic [SUM_W-1:0]        r_d_norm;
    // stage E: packed result
    logic                    r_valid;
    logic [WORD_W-1:0]       r_bits;

    logic signed [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0]        n_mag;
    logic [POS_W-1:0]        n_pos;
    logic [SUM_W-1:0]        n_norm;
    logic [WORD_W-1:0]       n_bits;
    logic [SIG_W-1:0]        w_sig;
    logic                    w_guard;
    logic                    w_sticky;
    logic                    w_up;
    logic [SIG_W:0]          w_rnd;
    logic [EXP_W-1:0]        w_exp;

    always_comb begin
        n_sum = (SUM_W'(i_side.n) <<< FRAC_BITS) + SUM_W'(i_acc);
        n_mag = r_a_sum[SUM_W-1] ? SUM_W'(-r_a_sum) : SUM_W'(r_a_sum);
    end

    always_comb begin
        n_pos = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (r_b_mag[i]) begin
                n_pos = POS_W'(i);
            end
        end
    end

    assign n_norm = r_c_mag << (POS_W'(SUM_W - 1) - r_c_pos);

    // round to nearest even on the bits below the 24-bit significand
    always_comb begin
        w_sig    = r_d_norm[SUM_W-1 -: SIG_W];
        w_guard  = r_d_norm[SUM_W-1-SIG_W];
        w_sticky = |r_d_norm[SUM_W-2-SIG_W:0];
        w_up     = w_guard && (w_sticky || w_sig[0]);
        w_rnd    = {1'b0, w_sig} + (SIG_W+1)'(w_up);
        w_exp    = EXP_W'(r_d_pos) + EXP_W'(EXP_OFF) + EXP_W'(w_rnd[SIG_W]);
        if (r_d_side.spec) begin
            n_bits = r_d_side.spec_bits;
        end else if (r_d_zero) begin
            n_bits = ZERO_BITS;
        end else begin
            n_bits = {r_d_neg, w_exp, w_rnd[MANT_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_side.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_valid   <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= i_side;
            r_a_sum  <= n_sum;
            r_b_side <= r_a_side;
            r_b_neg  <= r_a_sum[SUM_W-1];
            r_b_mag  <= n_mag;
            r_c_side <= r_b_side;
            r_c_neg  <= r_b_neg;
            r_c_zero <= (r_b_mag == '0);
            r_c_mag  <= r_b_mag;
            r_c_pos  <= n_pos;
            r_d_side <= r_c_side;
            r_d_neg  <= r_c_neg;
            r_d_zero <= r_c_zero;
            r_d_pos  <= r_c_pos;
            r_d_norm <= n_norm;
            r_bits   <= n_bits;
        end
    end

    assign o_valid = r_valid;
    assign o_bits  = r_bits;

endmodule
`default_nettype wire
